// ----- design/hbrp_pkg.sv -----
package hbrp_pkg;

    // One header character plus framing and the resource size.
    typedef struct packed {
        logic [7:0]  header_byte;
        logic        last_byte;
        logic        no_header;
        logic [63:0] resource_size;
    } t_in;

    typedef struct packed {
        logic        satisfiable;
        logic        is_ranged;
        logic [63:0] range_start;
        logic [63:0] range_end;
    } t_out;

    // Parse state at the final word, handed to the range check.
    typedef struct packed {
        logic        no_header;
        logic        parse_ok;
        logic [63:0] start_value;
        logic [63:0] end_value;
        logic [63:0] size;
        logic [63:0] top;
    } t_snap;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_START,
        PH_END
    } t_phase;

    localparam logic [2:0] PREFIX_LEN  = 3'd6;
    localparam logic [2:0] PREFIX_LAST = 3'd5;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DASH = 8'h2d;

    // "bytes="
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // v*10 + d, saturating at all ones.
    function automatic logic [63:0] acc_digit(input logic [63:0] v, input logic [3:0] d);
        logic [67:0] p;
        p = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {64'b0, d};
        return (|p[67:64]) ? '1 : p[63:0];
    endfunction

endpackage

// ----- design/hbrp_parse.sv -----
module hbrp_parse #(
    parameter int MAX_DIGITS     = 31,
    parameter int MIN_HEADER_LEN = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  hbrp_pkg::t_in  i_item,
    output logic           o_final,
    output hbrp_pkg::t_snap o_snap
);
    import hbrp_pkg::*;

    localparam int CntW = $clog2(MIN_HEADER_LEN + 1);
    localparam int DigW = $clog2(MAX_DIGITS + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MIN_HEADER_LEN);
    localparam logic [DigW-1:0] DigMax = DigW'(MAX_DIGITS);

    t_phase        r_phase, n_phase;
    logic [2:0]    r_prefix_idx, n_prefix_idx;
    logic [CntW-1:0] r_byte_cnt, n_byte_cnt;
    logic [DigW-1:0] r_digit_cnt, n_digit_cnt;
    logic [63:0]   r_start, n_start;
    logic [63:0]   r_end, n_end;
    logic          r_failed, n_failed;

    logic          is_digit;
    logic [7:0]    ch;

    assign ch       = i_item.header_byte;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign o_final  = i_item.last_byte | i_item.no_header;

    always_comb begin
        n_phase      = r_phase;
        n_prefix_idx = r_prefix_idx;
        n_byte_cnt   = r_byte_cnt;
        n_digit_cnt  = r_digit_cnt;
        n_start      = r_start;
        n_end        = r_end;
        n_failed     = r_failed;

        if (r_byte_cnt < CntMax) begin
            n_byte_cnt = r_byte_cnt + 1'b1;
        end

        if (!r_failed) begin
            case (r_phase)
                PH_PREFIX: begin
                    if (r_prefix_idx >= PREFIX_LEN || ch != prefix_char(r_prefix_idx)) begin
                        n_failed = 1'b1;
                    end else begin
                        n_prefix_idx = r_prefix_idx + 1'b1;
                        if (r_prefix_idx == PREFIX_LAST) begin
                            n_phase = PH_START;
                        end
                    end
                end
                PH_START, PH_END: begin
                    if (r_digit_cnt >= DigMax) begin
                        // number already full: anything more fails, '-' too
                        n_failed = 1'b1;
                    end else if (is_digit) begin
                        if (r_phase == PH_START) begin
                            n_start = acc_digit(r_start, ch[3:0]);
                        end else begin
                            n_end = acc_digit(r_end, ch[3:0]);
                        end
                        n_digit_cnt = r_digit_cnt + 1'b1;
                    end else if (ch == CH_DASH && r_phase == PH_START) begin
                        n_phase     = PH_END;
                        n_digit_cnt = '0;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                default: n_failed = 1'b1;
            endcase
        end
    end

    always_comb begin
        o_snap.no_header   = i_item.no_header;
        o_snap.parse_ok    = !n_failed && (n_byte_cnt == CntMax) && (n_phase != PH_PREFIX);
        o_snap.start_value = n_start;
        o_snap.end_value   = n_end;
        o_snap.size        = i_item.resource_size;
        o_snap.top         = i_item.resource_size - 64'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && o_final)) begin
            r_phase      <= PH_PREFIX;
            r_prefix_idx <= '0;
            r_byte_cnt   <= '0;
            r_digit_cnt  <= '0;
            r_start      <= '0;
            r_end        <= '0;
            r_failed     <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_prefix_idx <= n_prefix_idx;
            r_byte_cnt   <= n_byte_cnt;
            r_digit_cnt  <= n_digit_cnt;
            r_start      <= n_start;
            r_end        <= n_end;
            r_failed     <= n_failed;
        end
    end

`ifndef NO_ASSERTIONS
    a_byte_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_cnt <= CntMax)
        else $error("length count passed its cap");

    a_digit_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_cnt <= DigMax)
        else $error("digit count passed its limit");

    a_prefix_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_PREFIX) |-> (r_prefix_idx == PREFIX_LEN))
        else $error("number phase entered without full prefix");
`endif

endmodule

// ----- design/hbrp_eval.sv -----
module hbrp_eval (
    input  hbrp_pkg::t_snap i_snap,
    output hbrp_pkg::t_out  o_result
);
    import hbrp_pkg::*;

    logic [63:0] end_fill;

    // zero or empty end means last byte of the resource
    assign end_fill = (i_snap.end_value == 64'd0) ? i_snap.top : i_snap.end_value;

    always_comb begin
        o_result = '0;
        if (i_snap.no_header) begin
            o_result.satisfiable = 1'b1;
            o_result.range_end   = i_snap.top;
        end else if (i_snap.parse_ok && (i_snap.start_value < i_snap.size)
                     && (end_fill >= i_snap.start_value)) begin
            o_result.satisfiable = 1'b1;
            o_result.is_ranged   = 1'b1;
            o_result.range_start = i_snap.start_value;
            o_result.range_end   = (end_fill > i_snap.top) ? i_snap.top : end_fill;
        end
    end

endmodule

// ----- design/http_byte_range_parser.sv -----
// Single byte-range parser for an HTTP Range header value. Feed the value one
// character per word with last_byte on the final character, or one word with
// no_header set when the request carries no Range header; resource_size is
// sampled from that final word. Each final word yields one result word:
// satisfiable/is_ranged plus the inclusive start and end offsets; other words
// yield nothing. The value must be at least MIN_HEADER_LEN characters, open
// with "bytes=", and hold decimal start digits, an optional '-', and decimal
// end digits, each number limited to MAX_DIGITS digits and saturating at all
// ones. Leading zeros are plain decimal. An empty or zero end means size-1, an
// end past the resource is clamped, and start >= size or end < start gives an
// unsatisfiable result with all other fields zero. No header gives the whole
// resource, 0..size-1 (size-1 wraps to all ones for an empty resource).
// Throughput is one word per cycle, sustained, while no final word waits on
// a full snapshot register. The accepting edge loads the input register,
// then the parse-state snapshot register and then the output register;
// the 64-bit multiply-by-ten accumulate sets the parse stage path and the
// 64-bit range compares set the check stage path. A result stalled at the
// output does not block input until both internal stages fill.
module http_byte_range_parser #(
    parameter int MAX_DIGITS     = 31,
    parameter int MIN_HEADER_LEN = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hbrp_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output hbrp_pkg::t_out o_result
);
    import hbrp_pkg::*;

    // input register
    logic  r_s1_v;
    t_in   r_s1;
    // snapshot of the parse at a final word
    logic  r_s2_v;
    t_snap r_s2;
    // output register
    logic  r_o_v;
    t_out  r_o;

    logic  out_adv, s2_fire, s2_free, s1_fire, is_final;
    t_snap snap;
    t_out  result;

    assign out_adv = !r_o_v || i_ready;
    assign s2_fire = r_s2_v && out_adv;
    assign s2_free = !r_s2_v || s2_fire;
    // non-final words only update parse state, so they never wait downstream
    assign s1_fire = r_s1_v && (!is_final || s2_free);
    assign o_ready = !r_s1_v || s1_fire;

    assign o_valid  = r_o_v;
    assign o_result = r_o;

    hbrp_parse #(
        .MAX_DIGITS     (MAX_DIGITS),
        .MIN_HEADER_LEN (MIN_HEADER_LEN)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_item  (r_s1),
        .o_final (is_final),
        .o_snap  (snap)
    );

    hbrp_eval u_eval (
        .i_snap   (r_s2),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_ready) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_fire && is_final) begin
            r_s2_v <= 1'b1;
        end else if (s2_fire) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && is_final) begin
            r_s2 <= snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_adv) begin
            r_o_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_o <= result;
        end
    end

`ifndef NO_ASSERTIONS
    a_unsat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !r_o.satisfiable) |->
            (!r_o.is_ranged && r_o.range_start == 64'd0 && r_o.range_end == 64'd0))
        else $error("unsatisfiable result carries nonzero fields");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o.is_ranged) |-> (r_o.satisfiable && r_o.range_start <= r_o.range_end))
        else $error("ranged result with start past end");

    a_whole_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o.satisfiable && !r_o.is_ranged) |-> (r_o.range_start == 64'd0))
        else $error("whole-resource result with nonzero start");
`endif

endmodule
